FILE: sv/bsrc_pkg.sv
// Package for the deadlock-avoidance grant unit: beat types, codes and sizes.
package bsrc_pkg;

  localparam int unsigned MaxProcesses = 16;
  localparam int unsigned MaxResources = 4;
  localparam int unsigned WorkW        = 13;
  localparam logic [WorkW-1:0] WorkMax = 13'd8191;

  typedef enum logic [1:0] {
    ACT_AVAIL = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_NEED  = 2'd2,
    ACT_REQ   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_NEED     = 3'd1,
    ST_AVAIL    = 3'd2,
    ST_UNSAFE   = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_PROCS = 1'b0,
    CFG_RES   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] process;
    logic [1:0] resource;
    logic [7:0] amount;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic       granted;
    logic [2:0] status;
  } out_beat_t;

endpackage

FILE: sv/bankers_safety_request_check_unit.sv
// Top level of the deadlock-avoidance grant unit.
// After reset a clearing pass over all MAX_PROCESSES*MAX_RESOURCES entries (64 by
// default) zeroes the allocation and need tables; the input stalls meanwhile. Load
// beats (write available, allocation or need) and request elements without last
// are applied while idle, without starting a run. A request element with last starts
// a decision run by a small sequencer around one shared compare/add unit. The
// allocation and need tables have a registered read, so every step that reads them
// has an address phase and then a data phase; steps on available, staged and work
// entries need no such split. The run checks need, then available, then overflow
// (a failing check ends the run), commits the request, copies available into work
// and sweeps for rows with zero allocation. The scan then looks for the lowest
// unfinished row whose need fits the work (a failing column ends the row early),
// adds that row's allocation to work and restarts after every finished row, until a
// pass finds none. The verdict then settles; an unsafe verdict rolls the commit back
// before the verdict is handed out. The input stalls for the whole run.
// The result sits in an output register and the next item is taken while it
// waits, provided no further decision is due.
module bankers_safety_request_check_unit #(
  parameter int unsigned MAX_PROCESSES = bsrc_pkg::MaxProcesses,
  parameter int unsigned MAX_RESOURCES = bsrc_pkg::MaxResources
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [4:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bsrc_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bsrc_pkg::out_beat_t out_data_o
);
  import bsrc_pkg::*;

  localparam int unsigned PW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int unsigned RW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int unsigned Cells = MAX_PROCESSES * MAX_RESOURCES;
  localparam int unsigned CW = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int unsigned NPW = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned NRW = $clog2(MAX_RESOURCES + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CNEED, S_CAVAIL, S_COVF, S_COMMIT, S_WINIT, S_EMPTY,
    S_FIT, S_ADD, S_FINAL, S_ROLL, S_DONE
  } state_e;

  state_e state_q;
  logic [7:0] avail_q [MAX_RESOURCES];
  logic [7:0] alloc_mem [Cells];
  logic [7:0] need_mem  [Cells];
  logic [7:0] alloc_rd_q, need_rd_q;
  logic [7:0] stage_q [MAX_RESOURCES];
  logic [WorkW-1:0] work_q [MAX_RESOURCES];
  logic [MAX_PROCESSES-1:0] fin_q;
  logic [4:0] cfg_np_q;
  logic [2:0] cfg_nr_q;
  logic [PW-1:0] proc_q, row_q;
  logic [RW-1:0] col_q;
  logic [CW-1:0] clr_q;
  logic          ph_q;     // table step: 0 address out, 1 data back
  logic          empty_q;
  logic          out_valid_q;
  out_beat_t     out_q;

  // Effective sizes after clamping.
  logic [NPW-1:0] np;
  logic [NRW-1:0] nr;
  always_comb begin
    if (cfg_np_q == 5'd0) np = NPW'(1);
    else if (32'(cfg_np_q) > MAX_PROCESSES) np = NPW'(MAX_PROCESSES);
    else np = NPW'(cfg_np_q);
    if (cfg_nr_q == 3'd0) nr = NRW'(1);
    else if (32'(cfg_nr_q) > MAX_RESOURCES) nr = NRW'(MAX_RESOURCES);
    else nr = NRW'(cfg_nr_q);
  end

  // Shared datapath: one table entry addressed by row/column.
  logic [PW-1:0] row_sel;
  logic [CW-1:0] cell_idx, ld_idx, mem_waddr;
  logic [7:0] a_cell, n_cell, s_col, v_col;
  logic [7:0] alloc_wdata, need_wdata;
  logic alloc_we, need_we, ld_ok;
  logic [WorkW-1:0] w_col;
  logic [8:0] sum9;
  logic [WorkW:0] wsum;
  logic col_last, row_last;
  assign row_sel = (state_q == S_EMPTY || state_q == S_FIT || state_q == S_ADD) ? row_q : proc_q;
  assign cell_idx = CW'(32'(row_sel) * MAX_RESOURCES + 32'(col_q));
  assign ld_idx = CW'(32'(in_data_i.process) * MAX_RESOURCES + 32'(in_data_i.resource));
  assign ld_ok  = 32'(in_data_i.process) < MAX_PROCESSES &&
                  32'(in_data_i.resource) < MAX_RESOURCES;
  assign a_cell = alloc_rd_q;
  assign n_cell = need_rd_q;
  assign s_col = stage_q[col_q];
  assign v_col = avail_q[col_q];
  assign w_col = work_q[col_q];
  assign sum9  = {1'b0, a_cell} + {1'b0, s_col};
  assign wsum  = {1'b0, w_col} + (WorkW+1)'(a_cell);
  assign col_last = (NRW'(col_q) + NRW'(1)) == nr;
  assign row_last = (NPW'(row_q) + NPW'(1)) == np;

  logic accept_in, out_take, busy;
  assign busy = state_q != S_IDLE;
  assign out_take = out_valid_q && !out_stall_i;
  // A deciding beat waits while a previous result is still unread.
  assign in_stall_o = busy ||
    (out_valid_q && in_data_i.action == ACT_REQ && in_data_i.last);
  assign accept_in = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Table write port: clearing pass, load beats, commit and rollback.
  always_comb begin
    alloc_we    = 1'b0;
    need_we     = 1'b0;
    mem_waddr   = cell_idx;
    alloc_wdata = '0;
    need_wdata  = '0;
    unique case (state_q)
      S_CLEAR: begin
        alloc_we  = 1'b1;
        need_we   = 1'b1;
        mem_waddr = clr_q;
      end
      S_IDLE: if (accept_in && ld_ok) begin
        mem_waddr   = ld_idx;
        alloc_wdata = in_data_i.amount;
        need_wdata  = in_data_i.amount;
        alloc_we    = in_data_i.action == ACT_ALLOC;
        need_we     = in_data_i.action == ACT_NEED;
      end
      S_COMMIT: if (ph_q) begin
        alloc_we    = 1'b1;
        need_we     = 1'b1;
        alloc_wdata = a_cell + s_col;
        need_wdata  = n_cell - s_col;
      end
      S_ROLL: if (ph_q) begin
        alloc_we    = 1'b1;
        need_we     = 1'b1;
        alloc_wdata = a_cell - s_col;
        need_wdata  = n_cell + s_col;
      end
      default: ;
    endcase
  end

  // Allocation and need tables, registered read at the sequencer's address.
  always_ff @(posedge clk_i) begin
    if (alloc_we) alloc_mem[mem_waddr] <= alloc_wdata;
    if (need_we) need_mem[mem_waddr] <= need_wdata;
    alloc_rd_q <= alloc_mem[cell_idx];
    need_rd_q  <= need_mem[cell_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      for (int i = 0; i < MAX_RESOURCES; i++) begin
        avail_q[i] <= '0; stage_q[i] <= '0; work_q[i] <= '0;
      end
      fin_q <= '0;
      cfg_np_q <= 5'd16;
      cfg_nr_q <= 3'd4;
      proc_q <= '0; row_q <= '0; col_q <= '0; empty_q <= 1'b0;
      clr_q <= '0; ph_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_PROCS: cfg_np_q <= cfg_data_i;
          CFG_RES:   cfg_nr_q <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (out_take) out_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          if (clr_q == CW'(Cells - 1)) state_q <= S_IDLE;
          else clr_q <= clr_q + CW'(1);
        end
        S_IDLE: if (accept_in) begin
          unique case (action_e'(in_data_i.action))
            ACT_AVAIL: if (32'(in_data_i.resource) < MAX_RESOURCES)
              avail_q[RW'(in_data_i.resource)] <= in_data_i.amount;
            ACT_ALLOC, ACT_NEED: ;
            ACT_REQ: begin
              logic [RW-1:0] rs;
              rs = RW'(in_data_i.resource);
              if (32'(in_data_i.resource) < MAX_RESOURCES) stage_q[rs] <= in_data_i.amount;
              if (in_data_i.last) begin
                col_q <= '0;
                proc_q <= PW'(in_data_i.process);
                if (32'(in_data_i.process) >= MAX_PROCESSES) begin
                  out_q <= '{granted: 1'b0, status: ST_NEED};
                  state_q <= S_DONE;
                end else state_q <= S_CNEED;
              end
            end
            default: ;
          endcase
        end
        S_CNEED: begin
          if (!ph_q) ph_q <= 1'b1;
          else begin
            ph_q <= 1'b0;
            if (s_col > n_cell) begin
              out_q <= '{granted: 1'b0, status: ST_NEED}; state_q <= S_DONE;
            end else if (col_last) begin
              col_q <= '0; state_q <= S_CAVAIL;
            end else col_q <= col_q + RW'(1);
          end
        end
        S_CAVAIL: begin
          if (s_col > v_col) begin
            out_q <= '{granted: 1'b0, status: ST_AVAIL}; state_q <= S_DONE;
          end else if (col_last) begin
            col_q <= '0; state_q <= S_COVF;
          end else col_q <= col_q + RW'(1);
        end
        S_COVF: begin
          if (!ph_q) ph_q <= 1'b1;
          else begin
            ph_q <= 1'b0;
            if (sum9[8]) begin
              out_q <= '{granted: 1'b0, status: ST_OVERFLOW}; state_q <= S_DONE;
            end else if (col_last) begin
              col_q <= '0; state_q <= S_COMMIT;
            end else col_q <= col_q + RW'(1);
          end
        end
        S_COMMIT: begin
          // Table writes come from the write port in the data phase.
          if (!ph_q) ph_q <= 1'b1;
          else begin
            ph_q <= 1'b0;
            avail_q[col_q] <= v_col - s_col;
            if (col_last) begin
              col_q <= '0; state_q <= S_WINIT;
            end else col_q <= col_q + RW'(1);
          end
        end
        S_WINIT: begin
          work_q[col_q] <= WorkW'(v_col);
          if (col_last) begin
            col_q <= '0; row_q <= '0; empty_q <= 1'b1; fin_q <= '0; state_q <= S_EMPTY;
          end else col_q <= col_q + RW'(1);
        end
        S_EMPTY: begin
          if (!ph_q) ph_q <= 1'b1;
          else begin
            ph_q <= 1'b0;
            if (col_last) begin
              fin_q[row_q] <= empty_q && (a_cell == 8'd0);
              empty_q <= 1'b1;
              col_q <= '0;
              if (row_last) begin
                row_q <= '0; state_q <= S_FIT;
              end else row_q <= row_q + PW'(1);
            end else begin
              if (a_cell != 8'd0) empty_q <= 1'b0;
              col_q <= col_q + RW'(1);
            end
          end
        end
        S_FIT: begin
          if (!ph_q) ph_q <= 1'b1;
          else begin
            ph_q <= 1'b0;
            // Skip finished rows; a failing column ends the row early.
            if (fin_q[row_q] || WorkW'(n_cell) > w_col) begin
              col_q <= '0;
              if (row_last) state_q <= S_FINAL;
              else row_q <= row_q + PW'(1);
            end else if (col_last) begin
              col_q <= '0; state_q <= S_ADD;
            end else col_q <= col_q + RW'(1);
          end
        end
        S_ADD: begin
          if (!ph_q) ph_q <= 1'b1;
          else begin
            ph_q <= 1'b0;
            work_q[col_q] <= wsum[WorkW] || wsum[WorkW-1:0] > WorkMax ? WorkMax
                             : wsum[WorkW-1:0];
            if (col_last) begin
              fin_q[row_q] <= 1'b1;
              col_q <= '0; row_q <= '0; state_q <= S_FIT;
            end else col_q <= col_q + RW'(1);
          end
        end
        S_FINAL: begin
          logic safe;
          safe = 1'b1;
          for (int i = 0; i < MAX_PROCESSES; i++)
            if (NPW'(i) < np && !fin_q[i]) safe = 1'b0;
          col_q <= '0;
          if (safe) begin
            out_q <= '{granted: 1'b1, status: ST_GRANTED}; state_q <= S_DONE;
          end else state_q <= S_ROLL;
        end
        S_ROLL: begin
          if (!ph_q) ph_q <= 1'b1;
          else begin
            ph_q <= 1'b0;
            avail_q[col_q] <= v_col + s_col;
            if (col_last) begin
              out_q <= '{granted: 1'b0, status: ST_UNSAFE}; state_q <= S_DONE;
            end else col_q <= col_q + RW'(1);
          end
        end
        S_DONE: begin
          // Output register is free here: deciding beats wait for it.
          for (int i = 0; i < MAX_RESOURCES; i++) stage_q[i] <= '0;
          out_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the deadlock-avoidance grant unit: directed table, then random beats.
`timescale 1ns / 1ps

module testbench;
  import bsrc_pkg::*;

  // Decisions are far slower than load beats.
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned IdleLimit   = 40000;
  localparam int unsigned RandItems   = 450;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic      cfg_index_i = 1'b0;
  logic [4:0] cfg_data_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_data_o;

  bankers_safety_request_check_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the block's tables and registers.
  logic [7:0] avail_tbl [MaxResources];
  logic [7:0] alloc_tbl [MaxProcesses*MaxResources];
  logic [7:0] need_tbl  [MaxProcesses*MaxResources];
  logic [7:0] staged    [MaxResources];
  logic [4:0] procs_reg;
  logic [2:0] res_reg;

  out_beat_t grant_q[$];   // verdicts still owed by the block
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;

  typedef struct {
    in_beat_t  b;
    bit        typed;   // expected verdict given in the row itself
    out_beat_t exp;
  } row_t;
  row_t rows[$];

  function automatic in_beat_t beat(action_e a, int p, int r, int amt, bit l);
    in_beat_t b;
    b.action = a; b.process = p[3:0]; b.resource = r[1:0];
    b.amount = amt[7:0]; b.last = l;
    return b;
  endfunction

  function automatic out_beat_t verdict(status_e s);
    out_beat_t o;
    o.granted = (s == ST_GRANTED);
    o.status  = s;
    return o;
  endfunction

  // Safety scan over the shadow tables: lowest fitting row first, restart after each.
  function automatic bit state_is_safe(int np, int nr);
    int work[MaxResources];
    bit done[MaxProcesses];
    bit progressed, fits;
    for (int r = 0; r < nr; r++) work[r] = avail_tbl[r];
    for (int p = 0; p < np; p++) begin
      done[p] = 1'b1;
      for (int r = 0; r < nr; r++) if (alloc_tbl[p*MaxResources+r] != 0) done[p] = 1'b0;
    end
    do begin
      progressed = 1'b0;
      for (int p = 0; p < np && !progressed; p++) begin
        fits = !done[p];
        for (int r = 0; r < nr && fits; r++)
          if (need_tbl[p*MaxResources+r] > work[r]) fits = 1'b0;
        if (fits) begin
          for (int r = 0; r < nr; r++) begin
            work[r] += alloc_tbl[p*MaxResources+r];
            if (work[r] > WorkMax) work[r] = WorkMax;
          end
          done[p] = 1'b1;
          progressed = 1'b1;
        end
      end
    end while (progressed);
    for (int p = 0; p < np; p++) if (!done[p]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic status_e grant_decision(int pr);
    int np, nr, base;
    np = (procs_reg == 0) ? 1 : (procs_reg > MaxProcesses) ? MaxProcesses : procs_reg;
    nr = (res_reg == 0) ? 1 : (res_reg > MaxResources) ? MaxResources : res_reg;
    base = pr * MaxResources;
    for (int r = 0; r < nr; r++) if (staged[r] > need_tbl[base+r]) return ST_NEED;
    for (int r = 0; r < nr; r++) if (staged[r] > avail_tbl[r]) return ST_AVAIL;
    for (int r = 0; r < nr; r++) if (int'(alloc_tbl[base+r]) + staged[r] > 255) return ST_OVERFLOW;
    for (int r = 0; r < nr; r++) begin
      alloc_tbl[base+r] += staged[r];
      avail_tbl[r]      -= staged[r];
      need_tbl[base+r]  -= staged[r];
    end
    if (state_is_safe(np, nr)) return ST_GRANTED;
    for (int r = 0; r < nr; r++) begin
      alloc_tbl[base+r] -= staged[r];
      avail_tbl[r]      += staged[r];
      need_tbl[base+r]  += staged[r];
    end
    return ST_UNSAFE;
  endfunction

  // Update the shadow state for one accepted beat; returns 1 when a verdict is due.
  function automatic bit apply_beat(in_beat_t b, output out_beat_t o);
    int idx;
    idx = b.process * MaxResources + b.resource;
    o = '0;
    case (action_e'(b.action))
      ACT_AVAIL: avail_tbl[b.resource] = b.amount;
      ACT_ALLOC: alloc_tbl[idx] = b.amount;
      ACT_NEED:  need_tbl[idx] = b.amount;
      default: begin
        staged[b.resource] = b.amount;
        if (b.last) begin
          o = verdict(grant_decision(b.process));
          for (int r = 0; r < MaxResources; r++) staged[r] = '0;
          return 1'b1;
        end
      end
    endcase
    return 1'b0;
  endfunction

  // Sender: bursts of random length, random gaps between them; valid stays high inside a burst.
  task automatic send(in_beat_t b, bit typed = 1'b0, out_beat_t typed_exp = '0);
    out_beat_t o;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_data_i  <= b;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    if (apply_beat(b, o)) grant_q.push_back(typed ? typed_exp : o);
  endtask

  // Wait for all verdicts, then let any trailing load beat settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [4:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PROCS) procs_reg = val;
    else res_reg = val[2:0];
  endtask

  function automatic int rand_amount();
    case ($urandom_range(0, 9))
      0:       return 255;
      1:       return $urandom_range(0, 255);
      2:       return 0;
      default: return $urandom_range(0, 12);
    endcase
  endfunction

  // Receiver stall pattern: modes of random length - never, sparse, heavy, long holds.
  int unsigned stall_mode = 0, stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(10, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 4) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ($urandom_range(0, 30) != 0) ? out_stall_i : ~out_stall_i;
    endcase
  end

  // Verdict checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (grant_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected verdict %0d/%0d", out_data_o.granted,
                                       out_data_o.status);
      end else begin
        out_beat_t e;
        e = grant_q.pop_front();
        if (out_data_o.granted !== e.granted || out_data_o.status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("verdict mismatch: expected granted %0d status %0d, got %0d %0d",
                     e.granted, e.status, out_data_o.granted, out_data_o.status);
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [4:0] cfg_p [6] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd9};
    logic [4:0] cfg_r [6] = '{5'd4, 5'd1, 5'd0, 5'd7, 5'd2, 5'd3};
    int pr, n;
    for (int r = 0; r < MaxResources; r++) begin avail_tbl[r] = '0; staged[r] = '0; end
    for (int i = 0; i < MaxProcesses*MaxResources; i++) begin
      alloc_tbl[i] = '0; need_tbl[i] = '0;
    end
    procs_reg = 5'd16;
    res_reg   = 3'd4;

    // Directed rows. Typed verdicts only where the answer is obvious.
    rows.push_back('{beat(ACT_REQ, 0, 0, 0, 1), 1, verdict(ST_GRANTED)});   // empty tables
    rows.push_back('{beat(ACT_REQ, 0, 0, 1, 1), 1, verdict(ST_NEED)});      // no need yet
    rows.push_back('{beat(ACT_NEED, 0, 0, 255, 1), 0, '0});                 // last on a load
    rows.push_back('{beat(ACT_REQ, 0, 0, 1, 1), 1, verdict(ST_AVAIL)});     // nothing free
    rows.push_back('{beat(ACT_AVAIL, 0, 0, 255, 0), 0, '0});
    rows.push_back('{beat(ACT_AVAIL, 0, 1, 10, 0), 0, '0});
    rows.push_back('{beat(ACT_AVAIL, 0, 3, 255, 0), 0, '0});
    rows.push_back('{beat(ACT_ALLOC, 0, 0, 255, 0), 0, '0});
    rows.push_back('{beat(ACT_REQ, 0, 0, 1, 1), 1, verdict(ST_OVERFLOW)});  // 255 + 1
    rows.push_back('{beat(ACT_ALLOC, 0, 0, 0, 0), 0, '0});
    // Unsafe case: taking all of column 1 leaves row 2 stuck.
    rows.push_back('{beat(ACT_ALLOC, 2, 1, 5, 0), 0, '0});
    rows.push_back('{beat(ACT_NEED, 2, 1, 20, 0), 0, '0});
    rows.push_back('{beat(ACT_NEED, 3, 1, 10, 0), 0, '0});
    rows.push_back('{beat(ACT_REQ, 3, 1, 10, 1), 0, '0});
    // Multi-element request, then a request for the stuck row.
    rows.push_back('{beat(ACT_NEED, 3, 0, 7, 0), 0, '0});
    rows.push_back('{beat(ACT_REQ, 3, 0, 7, 0), 0, '0});
    rows.push_back('{beat(ACT_REQ, 3, 1, 5, 1), 0, '0});
    rows.push_back('{beat(ACT_REQ, 2, 1, 5, 1), 0, '0});
    // Highest process row and last column.
    rows.push_back('{beat(ACT_NEED, 15, 3, 255, 0), 0, '0});
    rows.push_back('{beat(ACT_REQ, 15, 3, 255, 1), 0, '0});
    rows.push_back('{beat(ACT_REQ, 15, 2, 0, 0), 0, '0});
    rows.push_back('{beat(ACT_REQ, 15, 3, 0, 1), 0, '0});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send(rows[i].b, rows[i].typed, rows[i].exp);
    drain();

    // Random phases, one setting of the size registers each; mostly well-formed request sequences.
    foreach (cfg_p[k]) begin
      write_cfg(CFG_PROCS, cfg_p[k]);
      write_cfg(CFG_RES, cfg_r[k]);
      n = 0;
      while (n < RandItems / 6) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            send(beat(ACT_AVAIL, $urandom_range(0, 15), $urandom_range(0, 3),
                      rand_amount(), $urandom_range(0, 1)));
            n++;
          end
          2, 3: begin
            send(beat(ACT_ALLOC, $urandom_range(0, 15), $urandom_range(0, 3),
                      rand_amount(), $urandom_range(0, 1)));
            n++;
          end
          4, 5: begin
            send(beat(ACT_NEED, $urandom_range(0, 15), $urandom_range(0, 3),
                      rand_amount(), $urandom_range(0, 1)));
            n++;
          end
          9: begin
            // stray request element, possibly deciding with odd staging
            send(beat(ACT_REQ, $urandom_range(0, 15), $urandom_range(0, 3),
                      rand_amount(), $urandom_range(0, 1)));
            n++;
          end
          default: begin
            pr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
            for (int r = 0; r < MaxResources; r++) begin
              send(beat(ACT_REQ, pr, r, ($urandom_range(0, 2) == 0) ? rand_amount()
                        : $urandom_range(0, 3), r == MaxResources - 1));
              n++;
            end
          end
        endcase
      end
      drain();
    end

    if (mismatches == 0 && grant_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/bsrc_pkg.sv
sv/bankers_safety_request_check_unit.sv
bench/testbench.sv
